/* rtl/ssg_pkg.sv */
`timescale 1ns / 1ps

package ssg_pkg;

   // Default coordinate register width
   localparam int COORD_BITS_DEFAULT = 16;

   // Width of every numeric input field and reported coordinate
   localparam int FIELD_BITS = 16;

   // Scan indices and point counts (span/step may reach +32768)
   localparam int IDX_BITS = FIELD_BITS + 1;

   // Quotient bits the divider retires per cycle
   localparam int DIV_RADIX_BITS = 2;

   // Action codes
   localparam logic [2:0] ACT_SET     = 3'd0;
   localparam logic [2:0] ACT_MATRIX  = 3'd1;
   localparam logic [2:0] ACT_DEPTH   = 3'd2;
   localparam logic [2:0] ACT_ADVANCE = 3'd3;
   localparam logic [2:0] ACT_STOP    = 3'd4;

   // Result kinds
   localparam logic [2:0] KIND_POINT  = 3'd0;
   localparam logic [2:0] KIND_FINISH = 3'd1;
   localparam logic [2:0] KIND_ABORT  = 3'd2;
   localparam logic [2:0] KIND_SET    = 3'd3;
   localparam logic [2:0] KIND_REJECT = 3'd4;

   // Axis numbers
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic [2:0]                   action;
      logic signed [FIELD_BITS-1:0] step_size;
      logic signed [FIELD_BITS-1:0] x_offset;
      logic signed [FIELD_BITS-1:0] y_offset;
      logic signed [FIELD_BITS-1:0] z_offset;
      logic signed [FIELD_BITS-1:0] x_span;
      logic signed [FIELD_BITS-1:0] y_span;
      logic signed [FIELD_BITS-1:0] z_span;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] x_pos;
      logic signed [FIELD_BITS-1:0] y_pos;
      logic signed [FIELD_BITS-1:0] z_pos;
      logic [2:0]                   result_kind;
      logic                         scan_last;
   } rsp_type;

   // Multiply-add issue control
   typedef struct packed {
      logic       valid;
      logic [1:0] axis;
      logic       sub;
   } mac_issue_type;

   // Multiply-add write-back control
   typedef struct packed {
      logic       valid;
      logic [1:0] axis;
   } mac_wr_type;

endpackage

/* rtl/ssg_chan_if.sv */
`timescale 1ns / 1ps

interface ssg_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/serpentine_scan_point_generator_top.sv */
`timescale 1ns / 1ps

// Serpentine 3-axis scan point generator.
// req_ch carries one command item (set position, start matrix or depth scan,
// advance, stop); rsp_ch returns exactly one item per command with the
// position after it, a result kind and a scan-end flag. Both are valid/ready.
// Commands are taken one at a time; req_ch.ready is high only while idle.
// Set position, stop, rejected or finishing advance go straight to the output
// stage. An advance to a new point first places x, y and z in turn through
// the shared multiply-add. A start runs three divisions on the shared divider,
// one per axis at 2 quotient bits per cycle, then placement (none for an
// empty grid).
// A finished result sits in an output register; the next command is taken
// while it waits. If rsp_ch stalls, the following command completes up to
// the output stage and waits there, so at most one further item is accepted.
// Reset (synchronous) clears the position, origin, counts and indices to
// zero and leaves no scan active.
module serpentine_scan_point_generator_top #(
   parameter int COORD_BITS = ssg_pkg::COORD_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ssg_chan_if.sink   req_ch,
   ssg_chan_if.source rsp_ch
);
   localparam int FB        = ssg_pkg::FIELD_BITS;
   localparam int IB        = ssg_pkg::IDX_BITS;
   localparam int WIDE_BITS = (COORD_BITS > FB) ? COORD_BITS : FB;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIV_GO   = 3'd1;
   localparam logic [2:0] ST_DIV_WAIT = 3'd2;
   localparam logic [2:0] ST_CHECK    = 3'd3;
   localparam logic [2:0] ST_PLACE    = 3'd4;
   localparam logic [2:0] ST_EMIT     = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [COORD_BITS-1:0]  cur_ff[3], cur_in[3];
   logic [COORD_BITS-1:0]  org_ff[3], org_in[3];
   logic [COORD_BITS-1:0]  start_ff[3], start_in[3];
   logic signed [FB-1:0]   span_ff[3], span_in[3];
   logic signed [IB-1:0]   cnt_ff[3], cnt_in[3];
   logic signed [IB-1:0]   idx_ff[3], idx_in[3];
   logic [1:0]             flag_ff, flag_in;
   logic signed [FB-1:0]   step_ff, step_in;
   logic                   mode_ff, mode_in;
   logic                   active_ff, active_in;
   logic [1:0]             ax_ff, ax_in;
   logic [2:0]             kind_ff, kind_in;
   logic                   last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ssg_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   ssg_pkg::req_type       req;
   logic                   req_fire;
   logic [COORD_BITS-1:0]  off_c[3];
   logic signed [WIDE_BITS-1:0] off_wide[3];
   logic signed [WIDE_BITS-1:0] pos_wide[3];

   logic                   div_start;
   logic                   div_done;
   logic signed [IB-1:0]   div_q;

   ssg_pkg::mac_issue_type issue;
   logic [COORD_BITS-1:0]  mac_base;
   logic signed [IB-1:0]   mac_idx;
   ssg_pkg::mac_wr_type    wr;
   logic [COORD_BITS-1:0]  wr_value;

   logic signed [IB-1:0]   nx_idx[3];
   logic [1:0]             nx_flag;
   logic                   nx_fin;

   assign req      = req_ch.payload;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // Offsets brought to coordinate width
   assign off_wide[0] = WIDE_BITS'(req.x_offset);
   assign off_wide[1] = WIDE_BITS'(req.y_offset);
   assign off_wide[2] = WIDE_BITS'(req.z_offset);
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         off_c[k]    = off_wide[k][COORD_BITS-1:0];
         pos_wide[k] = WIDE_BITS'($signed(cur_ff[k]));
      end
   end

   // Shared divider: point counts span / step
   ssg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (span_ff[ax_ff]),
      .divisor  (step_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Placement issue: one axis per cycle while ax_ff counts 0..2
   always_comb begin
      issue.valid = (state_ff == ST_PLACE) && (ax_ff != 2'd3);
      issue.axis  = ax_ff;
      issue.sub   = 1'b0;
      mac_base    = start_ff[0];
      mac_idx     = idx_ff[1];
      case (ax_ff)
         ssg_pkg::AXIS_X: begin
            mac_base  = start_ff[0];
            mac_idx   = idx_ff[1];
            issue.sub = mode_ff;
         end
         ssg_pkg::AXIS_Y: begin
            mac_base  = start_ff[1];
            mac_idx   = mode_ff ? idx_ff[1] : idx_ff[2];
            issue.sub = mode_ff;
         end
         ssg_pkg::AXIS_Z: begin
            mac_base = start_ff[2];
            mac_idx  = mode_ff ? idx_ff[2] : idx_ff[0];
         end
         default: begin
            mac_base = start_ff[2];
         end
      endcase
   end

   ssg_mac #(
      .COORD_BITS (COORD_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .base     (mac_base),
      .idx      (mac_idx),
      .step     (step_ff),
      .wr       (wr),
      .wr_value (wr_value)
   );

   // Serpentine successor of the current indices
   always_comb begin
      for (int k = 0; k < 3; k++) nx_idx[k] = idx_ff[k];
      nx_flag = flag_ff;
      nx_fin  = 1'b0;
      if (!flag_ff[1] && (idx_ff[2] < cnt_ff[2])) begin
         nx_idx[2] = idx_ff[2] + 1'b1;
      end else if (flag_ff[1] && (idx_ff[2] > 0)) begin
         nx_idx[2] = idx_ff[2] - 1'b1;
      end else if (!flag_ff[0] && (idx_ff[1] < cnt_ff[1])) begin
         nx_idx[1]  = idx_ff[1] + 1'b1;
         nx_flag[1] = ~flag_ff[1];
      end else if (flag_ff[0] && (idx_ff[1] > 0)) begin
         nx_idx[1]  = idx_ff[1] - 1'b1;
         nx_flag[1] = ~flag_ff[1];
      end else if (idx_ff[0] < cnt_ff[0]) begin
         nx_idx[0] = idx_ff[0] + 1'b1;
         nx_idx[2] = '0;
         nx_flag   = {1'b0, ~flag_ff[0]};
      end else begin
         nx_fin = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      flag_in      = flag_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      active_in    = active_ff;
      ax_in        = ax_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      for (int k = 0; k < 3; k++) begin
         cur_in[k]   = cur_ff[k];
         org_in[k]   = org_ff[k];
         start_in[k] = start_ff[k];
         span_in[k]  = span_ff[k];
         cnt_in[k]   = cnt_ff[k];
         idx_in[k]   = idx_ff[k];
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = ssg_pkg::KIND_REJECT;
               last_in  = 1'b0;
               state_in = ST_EMIT;
               case (req.action)
                  ssg_pkg::ACT_SET: begin
                     for (int k = 0; k < 3; k++) cur_in[k] = off_c[k];
                     kind_in = ssg_pkg::KIND_SET;
                  end
                  ssg_pkg::ACT_MATRIX, ssg_pkg::ACT_DEPTH: begin
                     if ((req.step_size != 0) && !active_ff) begin
                        for (int k = 0; k < 3; k++) begin
                           org_in[k]   = cur_ff[k];
                           start_in[k] = cur_ff[k] + off_c[k];
                           idx_in[k]   = '0;
                           cnt_in[k]   = '0;
                        end
                        span_in[0] = req.x_span;
                        span_in[1] = req.y_span;
                        span_in[2] = req.z_span;
                        step_in    = req.step_size;
                        mode_in    = (req.action == ssg_pkg::ACT_DEPTH);
                        flag_in    = '0;
                        active_in  = 1'b1;
                        ax_in      = ssg_pkg::AXIS_X;
                        state_in   = ST_DIV_GO;
                     end
                  end
                  ssg_pkg::ACT_ADVANCE: begin
                     if (active_ff) begin
                        if (nx_fin) begin
                           for (int k = 0; k < 3; k++) cur_in[k] = org_ff[k];
                           active_in = 1'b0;
                           kind_in   = ssg_pkg::KIND_FINISH;
                           last_in   = 1'b1;
                        end else begin
                           for (int k = 0; k < 3; k++) idx_in[k] = nx_idx[k];
                           flag_in  = nx_flag;
                           kind_in  = ssg_pkg::KIND_POINT;
                           ax_in    = ssg_pkg::AXIS_X;
                           state_in = ST_PLACE;
                        end
                     end
                  end
                  ssg_pkg::ACT_STOP: begin
                     active_in = 1'b0;
                     kind_in   = ssg_pkg::KIND_ABORT;
                     last_in   = 1'b1;
                  end
                  default: begin
                     kind_in = ssg_pkg::KIND_REJECT;
                  end
               endcase
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               // Map axis count to scan level (outer, middle, inner)
               case (ax_ff)
                  ssg_pkg::AXIS_X: begin
                     if (!mode_ff) cnt_in[1] = div_q;
                  end
                  ssg_pkg::AXIS_Y: begin
                     if (mode_ff) cnt_in[1] = div_q;
                     else cnt_in[2] = div_q;
                  end
                  ssg_pkg::AXIS_Z: begin
                     if (mode_ff) cnt_in[2] = div_q;
                     else cnt_in[0] = div_q;
                  end
                  default: begin
                     cnt_in[0] = cnt_ff[0];
                  end
               endcase
               if (ax_ff == ssg_pkg::AXIS_Z) begin
                  state_in = ST_CHECK;
               end else begin
                  ax_in    = ax_ff + 1'b1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_CHECK: begin
            // Negative count on any level: empty grid
            if (cnt_ff[0] < 0 || cnt_ff[1] < 0 || cnt_ff[2] < 0) begin
               for (int k = 0; k < 3; k++) cur_in[k] = org_ff[k];
               active_in = 1'b0;
               kind_in   = ssg_pkg::KIND_FINISH;
               last_in   = 1'b1;
               state_in  = ST_EMIT;
            end else begin
               kind_in  = ssg_pkg::KIND_POINT;
               last_in  = 1'b0;
               ax_in    = ssg_pkg::AXIS_X;
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (wr.valid) cur_in[wr.axis] = wr_value;
            if (ax_ff == 2'd3) begin
               state_in = ST_EMIT;
            end else begin
               ax_in = ax_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.x_pos       = pos_wide[0][FB-1:0];
               rsp_data_in.y_pos       = pos_wide[1][FB-1:0];
               rsp_data_in.z_pos       = pos_wide[2][FB-1:0];
               rsp_data_in.result_kind = kind_ff;
               rsp_data_in.scan_last   = last_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= '0;
         step_ff      <= '0;
         mode_ff      <= 1'b0;
         active_ff    <= 1'b0;
         ax_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            cur_ff[k]   <= '0;
            org_ff[k]   <= '0;
            start_ff[k] <= '0;
            cnt_ff[k]   <= '0;
            idx_ff[k]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         step_ff      <= step_in;
         mode_ff      <= mode_in;
         active_ff    <= active_in;
         ax_ff        <= ax_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 3; k++) begin
            cur_ff[k]   <= cur_in[k];
            org_ff[k]   <= org_in[k];
            start_ff[k] <= start_in[k];
            cnt_ff[k]   <= cnt_in[k];
            idx_ff[k]   <= idx_in[k];
         end
      end
      for (int k = 0; k < 3; k++) span_ff[k] <= span_in[k];
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

`ifndef SYNTH
   // Scan end flag only on finished or aborted results
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.scan_last) |->
         (rsp_ch.payload.result_kind == ssg_pkg::KIND_FINISH ||
          rsp_ch.payload.result_kind == ssg_pkg::KIND_ABORT))
      else $error("scan_last on a result that is not a scan end");

   // Divider completes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider done outside of count phase");

   // Placement write-back only during placement
   assert property (@(posedge clock) disable iff (reset)
      wr.valid |-> (state_ff == ST_PLACE && $past(issue.valid)))
      else $error("position write-back outside of placement");
`endif

endmodule

/* rtl/ssg_div.sv */
`timescale 1ns / 1ps

// Signed truncating divider, restoring, DIV_RADIX_BITS quotient bits per cycle
module ssg_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [ssg_pkg::FIELD_BITS-1:0]  dividend,
   input  logic signed [ssg_pkg::FIELD_BITS-1:0]  divisor,
   output logic                                   done,
   output logic signed [ssg_pkg::IDX_BITS-1:0]    quotient
);
   localparam int NB         = ssg_pkg::FIELD_BITS;
   localparam int DIV_CYCLES = NB / ssg_pkg::DIV_RADIX_BITS;
   localparam int CNT_BITS   = $clog2(DIV_CYCLES);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic [NB-1:0]       dvs_ff, dvs_in;
   logic [NB:0]         rem_ff, rem_in;
   logic [NB-1:0]       quo_ff, quo_in;

   // Load magnitudes on start, then retire quotient bits
   always_comb begin
      logic [NB:0]   rem_v;
      logic [NB-1:0] quo_v;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rem_v   = rem_ff;
      quo_v   = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[NB-1] ^ divisor[NB-1];
         dvs_in  = divisor[NB-1] ? NB'(-divisor) : NB'(divisor);
         quo_in  = dividend[NB-1] ? NB'(-dividend) : NB'(dividend);
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < ssg_pkg::DIV_RADIX_BITS; i++) begin
            rem_v = {rem_v[NB-1:0], quo_v[NB-1]};
            quo_v = {quo_v[NB-2:0], 1'b0};
            if (rem_v >= {1'b0, dvs_ff}) begin
               rem_v    = rem_v - {1'b0, dvs_ff};
               quo_v[0] = 1'b1;
            end
         end
         rem_in = rem_v;
         quo_in = quo_v;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

/* rtl/ssg_mac.sv */
`timescale 1ns / 1ps

// Shared multiply-add: value = base +/- index * step, one axis per issue
module ssg_mac #(
   parameter int COORD_BITS = ssg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ssg_pkg::mac_issue_type                issue,
   input  logic [COORD_BITS-1:0]                 base,
   input  logic signed [ssg_pkg::IDX_BITS-1:0]   idx,
   input  logic signed [ssg_pkg::FIELD_BITS-1:0] step,
   output ssg_pkg::mac_wr_type                   wr,
   output logic [COORD_BITS-1:0]                 wr_value
);
   localparam int PROD_BITS = ssg_pkg::IDX_BITS + ssg_pkg::FIELD_BITS;

   logic signed [PROD_BITS-1:0] prod_full;
   logic [COORD_BITS-1:0]       prod_ff;
   logic [COORD_BITS-1:0]       base_ff;
   logic                        sub_ff;
   logic [1:0]                  axis_ff;
   logic                        valid_ff;

   // Product register, then add or subtract on the way to write-back
   assign prod_full = PROD_BITS'(idx) * PROD_BITS'(step);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= issue.valid;
      end
      prod_ff <= prod_full[COORD_BITS-1:0];
      base_ff <= base;
      sub_ff  <= issue.sub;
      axis_ff <= issue.axis;
   end

   assign wr.valid = valid_ff;
   assign wr.axis  = axis_ff;
   assign wr_value = sub_ff ? (base_ff - prod_ff) : (base_ff + prod_ff);

endmodule

/* bench/ssg_scan_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, predicts the position and kind of every result item
// from the accepted command items, and compares in order.
module ssg_scan_checker
   import ssg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      awaited_count
);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // Scan levels and walk direction bits
   localparam int OUTER = 0;
   localparam int MIDDLE = 1;
   localparam int INNER = 2;
   localparam int MIDDLE_BACK = 0;
   localparam int INNER_BACK = 1;

   // Stage and scan state
   coord_type  stage_pos [3];
   coord_type  origin_pos [3];
   coord_type  scan_base [3];
   int         level_count [3];
   int         level_index [3];
   logic [1:0] walk_dir;
   int         grid_step;
   bit         depth_mode;
   bit         scanning;

   rsp_type    awaited_results [$];
   rsp_type    oldest;
   rsp_type    predicted;
   int         fails;

   // Put the stage on the grid point given by the current indices
   function automatic void place_point();
      int drop;
      if (!depth_mode) begin
         stage_pos[AXIS_Z] = scan_base[AXIS_Z] +
                             coord_type'(level_index[OUTER] * grid_step);
         stage_pos[AXIS_X] = scan_base[AXIS_X] +
                             coord_type'(level_index[MIDDLE] * grid_step);
         stage_pos[AXIS_Y] = scan_base[AXIS_Y] +
                             coord_type'(level_index[INNER] * grid_step);
      end else begin
         // x and y sink together by one step per row
         drop = level_index[MIDDLE] * grid_step;
         stage_pos[AXIS_X] = scan_base[AXIS_X] - coord_type'(drop);
         stage_pos[AXIS_Y] = scan_base[AXIS_Y] - coord_type'(drop);
         stage_pos[AXIS_Z] = scan_base[AXIS_Z] +
                             coord_type'(level_index[INNER] * grid_step);
      end
   endfunction

   function automatic void return_home();
      for (int k = 0; k < 3; k++) stage_pos[k] = origin_pos[k];
      scanning = 1'b0;
   endfunction

   // Apply one command item and return the result item it should produce
   function automatic rsp_type predict_scan_result(req_type cmd);
      rsp_type             res;
      int                  quot [3];
      int                  step;
      bit                  moved;
      logic signed [31:0]  wide;
      res.result_kind = KIND_REJECT;
      res.scan_last = 1'b0;
      case (cmd.action)
         ACT_SET: begin
            stage_pos[AXIS_X] = coord_type'($signed(cmd.x_offset));
            stage_pos[AXIS_Y] = coord_type'($signed(cmd.y_offset));
            stage_pos[AXIS_Z] = coord_type'($signed(cmd.z_offset));
            res.result_kind = KIND_SET;
         end
         ACT_MATRIX, ACT_DEPTH: begin
            step = $signed(cmd.step_size);
            if (step != 0 && !scanning) begin
               quot[AXIS_X] = int'($signed(cmd.x_span)) / step;
               quot[AXIS_Y] = int'($signed(cmd.y_span)) / step;
               quot[AXIS_Z] = int'($signed(cmd.z_span)) / step;
               for (int k = 0; k < 3; k++) begin
                  origin_pos[k] = stage_pos[k];
                  level_index[k] = 0;
               end
               scan_base[AXIS_X] = stage_pos[AXIS_X] + coord_type'($signed(cmd.x_offset));
               scan_base[AXIS_Y] = stage_pos[AXIS_Y] + coord_type'($signed(cmd.y_offset));
               scan_base[AXIS_Z] = stage_pos[AXIS_Z] + coord_type'($signed(cmd.z_offset));
               depth_mode = (cmd.action == ACT_DEPTH);
               if (!depth_mode) begin
                  level_count[OUTER] = quot[AXIS_Z];
                  level_count[MIDDLE] = quot[AXIS_X];
                  level_count[INNER] = quot[AXIS_Y];
               end else begin
                  // single pass: rows follow y, z is the serpentine axis
                  level_count[OUTER] = 0;
                  level_count[MIDDLE] = quot[AXIS_Y];
                  level_count[INNER] = quot[AXIS_Z];
               end
               grid_step = step;
               walk_dir = '0;
               scanning = 1'b1;
               if (level_count[OUTER] < 0 || level_count[MIDDLE] < 0 ||
                   level_count[INNER] < 0) begin
                  // empty grid ends at once
                  return_home();
                  res.result_kind = KIND_FINISH;
                  res.scan_last = 1'b1;
               end else begin
                  place_point();
                  res.result_kind = KIND_POINT;
               end
            end
         end
         ACT_ADVANCE: begin
            if (scanning) begin
               moved = 1'b1;
               if (!walk_dir[INNER_BACK] && level_index[INNER] < level_count[INNER]) begin
                  level_index[INNER]++;
               end else if (walk_dir[INNER_BACK] && level_index[INNER] > 0) begin
                  level_index[INNER]--;
               end else if (!walk_dir[MIDDLE_BACK] &&
                            level_index[MIDDLE] < level_count[MIDDLE]) begin
                  level_index[MIDDLE]++;
                  walk_dir[INNER_BACK] = !walk_dir[INNER_BACK];
               end else if (walk_dir[MIDDLE_BACK] && level_index[MIDDLE] > 0) begin
                  level_index[MIDDLE]--;
                  walk_dir[INNER_BACK] = !walk_dir[INNER_BACK];
               end else if (level_index[OUTER] < level_count[OUTER]) begin
                  // new outer index: middle turns, inner restarts forward from zero
                  level_index[OUTER]++;
                  walk_dir = {1'b0, !walk_dir[MIDDLE_BACK]};
                  level_index[INNER] = 0;
               end else begin
                  moved = 1'b0;
               end
               if (moved) begin
                  place_point();
                  res.result_kind = KIND_POINT;
               end else begin
                  return_home();
                  res.result_kind = KIND_FINISH;
                  res.scan_last = 1'b1;
               end
            end
         end
         ACT_STOP: begin
            scanning = 1'b0;
            res.result_kind = KIND_ABORT;
            res.scan_last = 1'b1;
         end
         default: ;
      endcase
      wide = stage_pos[AXIS_X];
      res.x_pos = wide[FIELD_BITS-1:0];
      wide = stage_pos[AXIS_Y];
      res.y_pos = wide[FIELD_BITS-1:0];
      wide = stage_pos[AXIS_Z];
      res.z_pos = wide[FIELD_BITS-1:0];
      return res;
   endfunction

   task automatic check_field(string name, int want, int seen);
      if (want != seen) begin
         fails++;
         $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
   endtask

   // Compare result items first: a result never belongs to a command taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            stage_pos[k] = '0;
            origin_pos[k] = '0;
            scan_base[k] = '0;
            level_count[k] = 0;
            level_index[k] = 0;
         end
         walk_dir = '0;
         grid_step = 0;
         depth_mode = 1'b0;
         scanning = 1'b0;
         awaited_results.delete();
         fails = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               fails++;
               $display("%0d ns: result item with none expected, actual x=%0d y=%0d z=%0d",
                        $time, rsp_item.x_pos, rsp_item.y_pos, rsp_item.z_pos);
               $display("%0d ns: unexpected result item kind=%0d", $time,
                        rsp_item.result_kind);
            end else begin
               oldest = awaited_results.pop_front();
               check_field("x_pos", oldest.x_pos, rsp_item.x_pos);
               check_field("y_pos", oldest.y_pos, rsp_item.y_pos);
               check_field("z_pos", oldest.z_pos, rsp_item.z_pos);
               check_field("result_kind", oldest.result_kind, rsp_item.result_kind);
               check_field("scan_last", oldest.scan_last, rsp_item.scan_last);
            end
         end
         if (req_valid && req_ready) begin
            predicted = predict_scan_result(req_item);
            awaited_results.push_back(predicted);
         end
      end
      awaited_count <= awaited_results.size();
      fail_count <= fails;
   end

endmodule

/* bench/tb_serpentine_scan_point_generator_top.sv */
`timescale 1ns / 1ps

module tb_serpentine_scan_point_generator_top;
   import ssg_pkg::*;

   // Action codes the block does not define
   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

   localparam int ITEM_TARGET = 1800;
   localparam int MAX_WAIT = 18;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;

   logic clock;
   logic reset;
   int   fail_total;
   int   awaited_total;
   int   items_sent;
   bit   quiet_stretch;

   ssg_chan_if #(.payload_type(req_type)) req_ch ();
   ssg_chan_if #(.payload_type(rsp_type)) rsp_ch ();

   serpentine_scan_point_generator_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ssg_scan_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_item      (req_ch.payload),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_item      (rsp_ch.payload),
      .fail_count    (fail_total),
      .awaited_count (awaited_total)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Wait drawn per item; none during a quiet stretch
   function automatic int draw_wait();
      if (quiet_stretch) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic req_type make_cmd(logic [2:0] act, int step, int xo, int yo, int zo,
                                        int xs, int ys, int zs);
      req_type c;
      c.action = act;
      c.step_size = FIELD_BITS'(step);
      c.x_offset = FIELD_BITS'(xo);
      c.y_offset = FIELD_BITS'(yo);
      c.z_offset = FIELD_BITS'(zo);
      c.x_span = FIELD_BITS'(xs);
      c.y_span = FIELD_BITS'(ys);
      c.z_span = FIELD_BITS'(zs);
      return c;
   endfunction

   function automatic req_type random_cmd(logic [2:0] act);
      return make_cmd(act, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // Span whose truncated quotient by step is exactly count
   function automatic int span_for(int count, int step);
      int mag;
      int rem;
      mag = (step < 0) ? -step : step;
      rem = $urandom_range(0, mag - 1);
      if (count * step < 0) rem = -rem;
      else if (count == 0 && $urandom_range(0, 1) == 1) rem = -rem;
      return count * step + rem;
   endfunction

   // Offer one item from a falling edge until it is taken
   task automatic send_command(req_type c);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (awaited_total != 0) @(negedge clock);
   endtask

   // Result side: random stalls, two long hold-offs while commands keep coming
   initial begin
      int hold;
      int taken;
      rsp_ch.ready = 1'b0;
      taken = 0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (taken == 650 || taken == 1350) hold = HOLD_CYCLES;
         else hold = draw_wait();
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Command side
   initial begin
      int         step;
      int         mag;
      int         points;
      int         n_x;
      int         n_y;
      int         n_z;
      int         pick;
      int         next_drain;
      logic [2:0] act;
      bit         deep;
      bit         ended;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      quiet_stretch = 1'b0;
      items_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle advance and idle stop
      send_command(make_cmd(ACT_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_cmd(ACT_STOP, 0, 0, 0, 0, 0, 0, 0));
      // extreme position, then a start with zero step
      send_command(make_cmd(ACT_SET, 0, 32767, -32768, -1, 0, 0, 0));
      send_command(make_cmd(ACT_MATRIX, 0, 5, 5, 5, 10, 10, 10));
      // 2x2x2 matrix with the most negative step and wrapping offsets
      send_command(make_cmd(ACT_MATRIX, -32768, 32767, -32768, 1, -32768, -32768, -32768));
      repeat (3) send_command(make_cmd(ACT_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
      // set position mid-scan, start while active
      send_command(make_cmd(ACT_SET, 0, 100, -200, 300, 0, 0, 0));
      send_command(make_cmd(ACT_DEPTH, 7, 0, 0, 0, 70, 70, 70));
      repeat (5) send_command(make_cmd(ACT_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
      // empty grids: negative z count in depth, negative x count in matrix
      send_command(make_cmd(ACT_DEPTH, 32767, 0, 0, 0, 0, 32767, -32768));
      send_command(make_cmd(ACT_MATRIX, 1, 0, 0, 0, -5, 3, 3));
      // depth scan ignores a negative x span; stopped part way
      send_command(make_cmd(ACT_DEPTH, 2, -7, 9, 4, -100, 4, 3));
      repeat (2) send_command(make_cmd(ACT_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_cmd(ACT_STOP, 0, 0, 0, 0, 0, 0, 0));
      for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++) send_command(random_cmd(3'(a)));
      wait_for_drain();

      next_drain = 300;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            // full scan with small counts, walked to its end unless a stop cuts it short
            deep = ($urandom_range(0, 3) == 0);
            act = deep ? ACT_DEPTH : ACT_MATRIX;
            n_x = $urandom_range(0, 3);
            n_y = $urandom_range(0, 3);
            n_z = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0) begin
               mag = $urandom_range(8192, 32768);
               n_x = 0;
               n_y = 0;
               n_z = 0;
            end else begin
               mag = $urandom_range(1, 2000);
               if ($urandom_range(0, 11) == 0) begin
                  case ($urandom_range(0, 2))
                     0: n_x = -1;
                     1: n_y = -1;
                     default: n_z = -1;
                  endcase
               end
            end
            step = ($urandom_range(0, 1) == 1) ? -mag : mag;
            if (deep) points = (n_y < 0 || n_z < 0) ? 0 : (n_y + 1) * (n_z + 1);
            else if (n_x < 0 || n_y < 0 || n_z < 0) points = 0;
            else points = (n_x + 1) * (n_y + 1) * (n_z + 1);
            send_command(make_cmd(act, step, $urandom, $urandom, $urandom,
                                  deep ? int'($urandom) : span_for(n_x, step),
                                  span_for(n_y, step), span_for(n_z, step)));
            ended = 1'b0;
            for (int i = 0; i < points && !ended; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < 2) begin
                  send_command(random_cmd(ACT_STOP));
                  ended = 1'b1;
               end else begin
                  if (pick < 4) send_command(random_cmd(ACT_SET));
                  else if (pick < 5) send_command(random_cmd(act));
                  else if (pick < 6)
                     send_command(random_cmd(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI))));
                  send_command(random_cmd(ACT_ADVANCE));
               end
            end
            if (!ended && $urandom_range(0, 6) == 0) send_command(random_cmd(ACT_ADVANCE));
         end else if (pick < 82) begin
            // start with raw fields: mostly huge or empty grids, cut short by stop
            send_command(random_cmd(($urandom_range(0, 1) == 1) ? ACT_DEPTH : ACT_MATRIX));
            repeat ($urandom_range(0, 8)) send_command(random_cmd(ACT_ADVANCE));
            send_command(random_cmd(ACT_STOP));
         end else begin
            case ($urandom_range(0, 4))
               0: send_command(random_cmd(ACT_SET));
               1: send_command(random_cmd(ACT_ADVANCE));
               2: send_command(random_cmd(ACT_STOP));
               3: send_command(make_cmd(($urandom_range(0, 1) == 1) ? ACT_DEPTH : ACT_MATRIX,
                                        0, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom));
               default:
                  send_command(random_cmd(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI))));
            endcase
         end
         if ($urandom_range(0, 19) == 0) quiet_stretch = !quiet_stretch;
         if (items_sent >= next_drain) begin
            wait_for_drain();
            next_drain += 600;
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_total == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/ssg_pkg.sv
rtl/ssg_chan_if.sv
rtl/ssg_div.sv
rtl/ssg_mac.sv
rtl/serpentine_scan_point_generator_top.sv
bench/ssg_scan_checker.sv
bench/tb_serpentine_scan_point_generator_top.sv
